@@ hw/rtl/pdc_pkg.sv @@
// Shared types, constants and hash function for the phrase dictionary counter.
package pdc_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int LOOKUP_SLOTS = 8192;
  localparam int ENTRY_AW     = $clog2(DICT_ENTRIES);
  localparam int PTR_W        = ENTRY_AW + 1;
  localparam int SLOT_AW      = $clog2(LOOKUP_SLOTS);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 8;
  localparam int COUNT_W      = 32;
  localparam int KEY_W        = PTR_W + BYTE_W;

  localparam logic [PTR_W-1:0]   ROOT_MARK = PTR_W'(DICT_ENTRIES);
  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(LOOKUP_SLOTS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [31:0]        HASH_MUL  = 32'd2654435761;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [PTR_W-1:0]   parent;
    logic [BYTE_W-1:0]  last_byte;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] uses;
  } entry_t;

  typedef struct packed {
    logic                full;
    logic [KEY_W-1:0]    key;
    logic [ENTRY_AW-1:0] entry;
  } slot_t;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_BUMP  = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  // Multiplicative hash; only the low slot-address bits of the product matter.
  function automatic logic [SLOT_AW-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [2*SLOT_AW-1:0] prod;
    prod = key[SLOT_AW-1:0] * HASH_MUL[SLOT_AW-1:0];
    return prod[SLOT_AW-1:0];
  endfunction

endpackage

@@ hw/rtl/pdc_ram.sv @@
// Generic simple dual-port synchronous RAM with registered read data.
module pdc_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/phrase_dictionary_counter_core.sv @@
// Top level of the phrase dictionary counter: sequencer around the slot and entry RAMs.
// After reset the block runs a clearing pass over the 8192 lookup slots, one slot per
// cycle, and stalls input until the pass is done; configuration writes are taken at any
// time. One transaction is worked at a time. A read command is accepted, then its entry
// RAM read data is loaded as the result. A fed byte is accepted, then probes the slots
// (linear probing from the hashed home slot, at least one probe), then has a bump step
// when the phrase ends under a non-root prefix and that prefix count is read, incremented
// with saturation and written back. A byte dropped for length ends at acceptance at the
// root, else after the bump step. The result sits in an output register; the next
// transaction is accepted only while the sequencer is idle and no result is held there
// by a stall, at the earliest in the cycle the held result is taken. Phrase lengths are
// tracked in a register for the current phrase, so the length limit needs no memory read.
module phrase_dictionary_counter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [11:0] in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_phrase_ended,
  output logic        out_entry_added,
  output logic        out_table_full,
  output logic [11:0] out_entry_index,
  output logic        out_entry_valid,
  output logic        out_entry_has_parent,
  output logic [11:0] out_entry_parent,
  output logic [7:0]  out_entry_byte,
  output logic [7:0]  out_entry_length,
  output logic [31:0] out_entry_count,
  output logic [12:0] out_entries_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_phrase_length
);

  localparam int EAW = pdc_pkg::ENTRY_AW;
  localparam int SAW = pdc_pkg::SLOT_AW;
  localparam int PW  = pdc_pkg::PTR_W;

  pdc_pkg::state_t state_r, state_nxt;

  logic [7:0]                 limit_r;
  logic [PW-1:0]              current_r, current_nxt;
  logic [7:0]                 cur_len_r, cur_len_nxt;
  logic [PW-1:0]              used_r, used_nxt;
  logic [SAW-1:0]             clr_idx_r, clr_idx_nxt;
  logic [SAW-1:0]             slot_addr_r, slot_addr_nxt;
  logic [SAW-1:0]             probe_cnt_r, probe_cnt_nxt;
  logic [pdc_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic                       added_r, added_nxt;
  logic [EAW-1:0]             add_idx_r, add_idx_nxt;
  logic                       rd_ok_r, rd_ok_nxt;
  logic [EAW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [EAW-1:0]             bump_addr_r;

  // slot RAM
  logic                       s_we;
  logic [SAW-1:0]             s_waddr, s_raddr;
  pdc_pkg::slot_t             s_wdata, s_rdata;
  // entry RAM
  logic                       e_we;
  logic [EAW-1:0]             e_waddr, e_raddr;
  pdc_pkg::entry_t            e_wdata, e_rdata;

  // result load
  logic        ld;
  logic        o_ended, o_added, o_valid, o_has_parent;
  logic [11:0] o_index, o_parent;
  logic [7:0]  o_byte, o_len;
  logic [31:0] o_count;

  logic                      accept;
  logic                      at_root;
  logic [7:0]                limit_eff;
  logic [pdc_pkg::KEY_W-1:0] key_in;
  logic                      ins;

  pdc_ram #(.AW(SAW), .DW($bits(pdc_pkg::slot_t))) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  pdc_ram #(.AW(EAW), .DW($bits(pdc_pkg::entry_t))) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != pdc_pkg::ST_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign at_root   = current_r[PW-1];
  assign limit_eff = (limit_r == 8'd0) ? 8'd1 : limit_r;
  assign key_in    = {(at_root ? pdc_pkg::ROOT_MARK : current_r), in_data_byte};

  always_comb begin
    state_nxt     = state_r;
    current_nxt   = current_r;
    cur_len_nxt   = cur_len_r;
    used_nxt      = used_r;
    clr_idx_nxt   = clr_idx_r;
    slot_addr_nxt = slot_addr_r;
    probe_cnt_nxt = probe_cnt_r;
    key_nxt       = key_r;
    added_nxt     = added_r;
    add_idx_nxt   = add_idx_r;
    rd_ok_nxt     = rd_ok_r;
    rd_idx_nxt    = rd_idx_r;
    s_we          = 1'b0;
    s_waddr       = slot_addr_r;
    s_wdata       = '0;
    s_raddr       = slot_addr_r;
    e_we          = 1'b0;
    e_waddr       = used_r[EAW-1:0];
    e_wdata       = '0;
    e_raddr       = current_r[EAW-1:0];
    ins           = 1'b0;
    ld            = 1'b0;
    o_ended       = 1'b0;
    o_added       = 1'b0;
    o_index       = '0;
    o_valid       = 1'b0;
    o_has_parent  = 1'b0;
    o_parent      = '0;
    o_byte        = '0;
    o_len         = '0;
    o_count       = '0;

    case (state_r)
      pdc_pkg::ST_CLR: begin
        // sweep every lookup slot to empty
        s_we        = 1'b1;
        s_waddr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == pdc_pkg::SLOT_LAST) begin
          state_nxt = pdc_pkg::ST_IDLE;
        end
      end

      pdc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == pdc_pkg::CMD_READ) begin
            e_raddr    = in_read_index;
            rd_idx_nxt = in_read_index;
            rd_ok_nxt  = ({1'b0, in_read_index} < used_r);
            state_nxt  = pdc_pkg::ST_READ;
          end else if (cur_len_r >= limit_eff) begin
            // over-long byte: drop it and end the phrase
            added_nxt   = 1'b0;
            current_nxt = pdc_pkg::ROOT_MARK;
            cur_len_nxt = '0;
            if (!at_root) begin
              e_raddr   = current_r[EAW-1:0];
              state_nxt = pdc_pkg::ST_BUMP;
            end else begin
              ld      = 1'b1;
              o_ended = 1'b1;
            end
          end else begin
            key_nxt       = key_in;
            s_raddr       = pdc_pkg::home_slot(key_in);
            slot_addr_nxt = s_raddr;
            probe_cnt_nxt = '0;
            state_nxt     = pdc_pkg::ST_PROBE;
          end
        end
      end

      pdc_pkg::ST_PROBE: begin
        if (s_rdata.full && s_rdata.key == key_r && {1'b0, s_rdata.entry} < used_r) begin
          // child exists: extend the phrase
          current_nxt = {1'b0, s_rdata.entry};
          cur_len_nxt = cur_len_r + 1'b1;
          ld          = 1'b1;
          state_nxt   = pdc_pkg::ST_IDLE;
        end else if (s_rdata.full && probe_cnt_r != pdc_pkg::SLOT_LAST) begin
          // advance to the next slot
          s_raddr       = slot_addr_r + 1'b1;
          slot_addr_nxt = s_raddr;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end else begin
          // miss: insert if an entry and a slot are free, then end the phrase
          ins = !s_rdata.full && !used_r[PW-1];
          if (ins) begin
            s_we            = 1'b1;
            s_waddr         = slot_addr_r;
            s_wdata.full    = 1'b1;
            s_wdata.key     = key_r;
            s_wdata.entry   = used_r[EAW-1:0];
            e_we            = 1'b1;
            e_waddr         = used_r[EAW-1:0];
            e_wdata.parent  = key_r[pdc_pkg::KEY_W-1 -: PW];
            e_wdata.last_byte = key_r[7:0];
            e_wdata.len     = cur_len_r + 1'b1;
            e_wdata.uses    = 32'd1;
            used_nxt        = used_r + 1'b1;
          end
          added_nxt   = ins;
          add_idx_nxt = used_r[EAW-1:0];
          current_nxt = pdc_pkg::ROOT_MARK;
          cur_len_nxt = '0;
          if (!at_root) begin
            e_raddr   = current_r[EAW-1:0];
            state_nxt = pdc_pkg::ST_BUMP;
          end else begin
            ld        = 1'b1;
            o_ended   = 1'b1;
            o_added   = ins;
            o_index   = ins ? used_r[EAW-1:0] : '0;
            state_nxt = pdc_pkg::ST_IDLE;
          end
        end
      end

      pdc_pkg::ST_BUMP: begin
        // write back the prefix count, saturating
        e_we         = 1'b1;
        e_waddr      = bump_addr_r;
        e_wdata      = e_rdata;
        e_wdata.uses = (e_rdata.uses == pdc_pkg::COUNT_MAX) ? e_rdata.uses
                                                            : e_rdata.uses + 1'b1;
        ld           = 1'b1;
        o_ended      = 1'b1;
        o_added      = added_r;
        o_index      = added_r ? add_idx_r : '0;
        state_nxt    = pdc_pkg::ST_IDLE;
      end

      pdc_pkg::ST_READ: begin
        ld      = 1'b1;
        o_index = rd_idx_r;
        if (rd_ok_r) begin
          o_valid      = 1'b1;
          o_has_parent = !e_rdata.parent[PW-1];
          o_parent     = e_rdata.parent[PW-1] ? '0 : e_rdata.parent[EAW-1:0];
          o_byte       = e_rdata.last_byte;
          o_len        = e_rdata.len;
          o_count      = e_rdata.uses;
        end
        state_nxt = pdc_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = pdc_pkg::ST_IDLE;
      end
    endcase
  end

  // the bump cycle writes back at the prefix address saved before the phrase returned to root
  always_ff @(posedge clk) begin
    if (state_nxt == pdc_pkg::ST_BUMP && state_r != pdc_pkg::ST_BUMP) begin
      bump_addr_r <= current_r[EAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pdc_pkg::ST_CLR;
      limit_r   <= 8'd255;
      current_r <= pdc_pkg::ROOT_MARK;
      cur_len_r <= '0;
      used_r    <= '0;
      clr_idx_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      current_r <= current_nxt;
      cur_len_r <= cur_len_nxt;
      used_r    <= used_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_max_phrase_length;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    slot_addr_r <= slot_addr_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    key_r       <= key_nxt;
    added_r     <= added_nxt;
    add_idx_r   <= add_idx_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_idx_r    <= rd_idx_nxt;
    if (ld) begin
      out_phrase_ended     <= o_ended;
      out_entry_added      <= o_added;
      out_table_full       <= used_nxt[PW-1];
      out_entry_index      <= o_index;
      out_entry_valid      <= o_valid;
      out_entry_has_parent <= o_has_parent;
      out_entry_parent     <= o_parent;
      out_entry_byte       <= o_byte;
      out_entry_length     <= o_len;
      out_entry_count      <= o_count;
      out_entries_used     <= used_nxt;
    end
  end

endmodule

@@ hw/rtl/pdc_checker.sv @@
// Port-level assertions for the phrase dictionary counter, bound to the top level.
module pdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_phrase_ended,
  input logic        out_entry_added,
  input logic        out_table_full,
  input logic        out_entry_valid,
  input logic [11:0] out_entry_index,
  input logic [12:0] out_entries_used
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_index))
    else $error("stalled result changed");

  // an insertion always ends the phrase
  a_add_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_added |-> out_phrase_ended)
    else $error("entry added without phrase end");

  // a read of a valid entry never reports feed flags
  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> !out_phrase_ended && !out_entry_added)
    else $error("read result carries feed flags");

  // full flag agrees with the entry count
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_table_full == (out_entries_used == 13'd4096))
    else $error("table_full disagrees with entries_used");

endmodule

bind phrase_dictionary_counter_core pdc_checker u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_phrase_ended (out_phrase_ended),
  .out_entry_added  (out_entry_added),
  .out_table_full   (out_table_full),
  .out_entry_valid  (out_entry_valid),
  .out_entry_index  (out_entry_index),
  .out_entries_used (out_entries_used)
);

@@ sim/phrase_dictionary_counter_checker.sv @@
// Checker for the phrase dictionary counter: predicts every result and compares it.
`timescale 1ns / 1ps

module phrase_dictionary_counter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [11:0] in_read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_phrase_ended,
  input  logic        out_entry_added,
  input  logic        out_table_full,
  input  logic [11:0] out_entry_index,
  input  logic        out_entry_valid,
  input  logic        out_entry_has_parent,
  input  logic [11:0] out_entry_parent,
  input  logic [7:0]  out_entry_byte,
  input  logic [7:0]  out_entry_length,
  input  logic [31:0] out_entry_count,
  input  logic [12:0] out_entries_used,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_max_phrase_length,
  output int          mismatch_count,
  output int          results_pending
);

  typedef struct packed {
    logic        phrase_ended;
    logic        entry_added;
    logic        table_full;
    logic [11:0] entry_index;
    logic        entry_valid;
    logic        entry_has_parent;
    logic [11:0] entry_parent;
    logic [7:0]  entry_byte;
    logic [7:0]  entry_length;
    logic [31:0] entry_count;
    logic [12:0] entries_used;
  } dict_result_t;

  logic [12:0] ent_parent [pdc_pkg::DICT_ENTRIES];
  logic [7:0]  ent_byte   [pdc_pkg::DICT_ENTRIES];
  logic [7:0]  ent_len    [pdc_pkg::DICT_ENTRIES];
  logic [31:0] ent_uses   [pdc_pkg::DICT_ENTRIES];
  bit          slot_busy  [pdc_pkg::LOOKUP_SLOTS];
  logic [31:0] slot_key   [pdc_pkg::LOOKUP_SLOTS];
  logic [11:0] slot_ent   [pdc_pkg::LOOKUP_SLOTS];
  logic [12:0] cur_phrase;
  int          used;
  logic [7:0]  len_limit;

  dict_result_t expected_results[$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  function automatic int hash_slot(input logic [31:0] key);
    logic [31:0] prod;
    prod = key * 32'd2654435761;
    return int'(prod % pdc_pkg::LOOKUP_SLOTS);
  endfunction

  function automatic void raise_count(input logic [12:0] e);
    if (e < pdc_pkg::DICT_ENTRIES && ent_uses[e] != pdc_pkg::COUNT_MAX) ent_uses[e]++;
  endfunction

  function automatic dict_result_t predict_result(input logic c, input logic [7:0] b,
                                                  input logic [11:0] r);
    dict_result_t res;
    int lim, len, s, n, child;
    bit hit, at_root;
    logic [12:0] parent;
    logic [31:0] key;
    res = '0;
    if (c != pdc_pkg::CMD_READ) begin
      lim     = (len_limit == 0) ? 1 : int'(len_limit);
      at_root = (cur_phrase >= pdc_pkg::ROOT_MARK);
      len     = at_root ? 0 : int'(ent_len[cur_phrase]);
      parent  = at_root ? pdc_pkg::ROOT_MARK : cur_phrase;
      key     = {11'd0, parent, b};
      hit     = 0;
      child   = 0;
      if (len + 1 <= lim) begin
        s = hash_slot(key);
        for (n = 0; n < pdc_pkg::LOOKUP_SLOTS; n++) begin
          if (!slot_busy[s]) break;
          if (slot_key[s] == key) begin
            hit   = 1;
            child = int'(slot_ent[s]);
            break;
          end
          s = (s + 1) % pdc_pkg::LOOKUP_SLOTS;
        end
      end
      if (len + 1 > lim) begin
        if (!at_root) raise_count(cur_phrase);
        cur_phrase = pdc_pkg::ROOT_MARK;
        res.phrase_ended = 1;
      end else if (hit && child < used) begin
        cur_phrase = 13'(child);
      end else begin
        if (used < pdc_pkg::DICT_ENTRIES) begin
          s = hash_slot(key);
          for (n = 0; n < pdc_pkg::LOOKUP_SLOTS && slot_busy[s]; n++)
            s = (s + 1) % pdc_pkg::LOOKUP_SLOTS;
          if (!slot_busy[s]) begin
            ent_parent[used] = parent;
            ent_byte[used]   = b;
            ent_len[used]    = 8'(len + 1);
            ent_uses[used]   = 1;
            slot_busy[s]     = 1;
            slot_key[s]      = key;
            slot_ent[s]      = 12'(used);
            res.entry_added  = 1;
            res.entry_index  = 12'(used);
            used++;
          end
        end
        if (!at_root) raise_count(cur_phrase);
        cur_phrase = pdc_pkg::ROOT_MARK;
        res.phrase_ended = 1;
      end
    end else begin
      res.entry_index = r;
      if (r < used) begin
        res.entry_valid = 1;
        if (ent_parent[r] < pdc_pkg::ROOT_MARK) begin
          res.entry_has_parent = 1;
          res.entry_parent     = ent_parent[r][11:0];
        end
        res.entry_byte   = ent_byte[r];
        res.entry_length = ent_len[r];
        res.entry_count  = ent_uses[r];
      end
    end
    res.table_full   = (used >= pdc_pkg::DICT_ENTRIES);
    res.entries_used = 13'(used);
    return res;
  endfunction

  always @(posedge clk) begin
    dict_result_t seen, want;
    if (!rst_n) begin
      for (int i = 0; i < pdc_pkg::LOOKUP_SLOTS; i++) slot_busy[i] = 0;
      cur_phrase = pdc_pkg::ROOT_MARK;
      used       = 0;
      len_limit  = 8'd255;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) len_limit = cfg_max_phrase_length;
      if (out_valid && !out_stall) begin
        seen = '{out_phrase_ended, out_entry_added, out_table_full, out_entry_index,
                 out_entry_valid, out_entry_has_parent, out_entry_parent, out_entry_byte,
                 out_entry_length, out_entry_count, out_entries_used};
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %p", seen);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("mismatch: expected %p actual %p", want, seen);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_cmd, in_data_byte, in_read_index));
    end
    results_pending <= expected_results.size();
  end

endmodule

@@ sim/phrase_dictionary_counter_core_tb.sv @@
// Testbench top for the phrase dictionary counter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module phrase_dictionary_counter_core_tb;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = pdc_pkg::CMD_FEED;
  logic [7:0]  in_data_byte = 8'd0;
  logic [11:0] in_read_index = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_phrase_ended, out_entry_added, out_table_full;
  logic [11:0] out_entry_index;
  logic        out_entry_valid, out_entry_has_parent;
  logic [11:0] out_entry_parent;
  logic [7:0]  out_entry_byte, out_entry_length;
  logic [31:0] out_entry_count;
  logic [12:0] out_entries_used;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_max_phrase_length = 8'd0;

  int mismatch_count, results_pending;
  int cycle_count = 0;
  int stall_left  = 0;
  bit quiet       = 0;   // no idling on either side while set

  always #5 clk = ~clk;

  phrase_dictionary_counter_core dut (.*);
  phrase_dictionary_counter_checker checker_i (.*);

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure: mostly short holds, a few long ones.
  always @(posedge clk) begin
    int roll;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70) stall_left = 0;
      else if (roll < 96) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(10, 40);
    end
    out_stall <= (stall_left > 0);
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one transaction and hold it until it is taken.
  task automatic send_cmd(input logic c, input logic [7:0] b, input logic [11:0] r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_data_byte  <= b;
    in_read_index <= r;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    send_cmd(pdc_pkg::CMD_FEED, b, 12'($urandom_range(0, 4095)));
  endtask

  task automatic read_entry(input logic [11:0] r);
    send_cmd(pdc_pkg::CMD_READ, 8'($urandom_range(0, 255)), r);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid             <= 1'b1;
    cfg_max_phrase_length <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a small alphabet so phrases grow and get reused; some reads and noise.
  task automatic random_phase(input int n, input int read_span);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) read_entry(12'($urandom_range(0, read_span)));
      else if (roll < 15) read_entry(12'($urandom_range(0, 4095)));
      else if (roll < 75) feed(8'($urandom_range(0, 3)));
      else feed(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of bytes and indexes at the reset limit.
    feed(8'h00); feed(8'hFF); feed(8'h00); feed(8'h00); feed(8'h00); feed(8'hFF);
    feed(8'hFF); feed(8'h00);
    read_entry(12'd0); read_entry(12'd1); read_entry(12'd3); read_entry(12'd4095);
    read_entry(12'd2048);
    drain();

    // Zero limit acts as one: second byte extends, third is dropped.
    write_limit(8'd0);
    feed(8'h5A); feed(8'h5A); feed(8'h5A); feed(8'hA5);
    read_entry(12'd0); read_entry(12'd4);
    drain();

    // Limit one, then short phrases forced to end by length.
    write_limit(8'd1);
    random_phase(100, 300);
    drain();
    write_limit(8'd3);
    random_phase(150, 400);
    drain();

    // Full limit without idling, then a pause for a drained pipe mid-stream.
    write_limit(8'd255);
    quiet = 1;
    random_phase(100, 400);
    quiet = 0;
    drain();
    random_phase(100, 500);
    drain();
    write_limit(8'd128);
    random_phase(150, 600);
    drain();
    write_limit(8'd17);
    random_phase(150, 700);
    drain();

    // Two-byte phrases over the whole byte range, with scattered reads.
    write_limit(8'd2);
    for (int i = 0; i < 330; i++) begin
      if ($urandom_range(0, 19) == 0) read_entry(12'($urandom_range(0, 4095)));
      else feed(8'($urandom_range(0, 255)));
    end
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
